// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define NECIRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define NECIRD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- design/necird_pkg.sv -----
// ----------------------------------------------------------------------------
// necird_pkg
// types, register indexes and threshold helpers of the nec ir frame decoder
// ----------------------------------------------------------------------------
package necird_pkg;

  localparam int unsigned DurW    = 15;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_REP_SPACE  = 3'd2,
    REG_BIT_MARK   = 3'd3,
    REG_ZERO_SPACE = 3'd4,
    REG_ONE_SPACE  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_VALID   = 2'd1,
    ST_REPEAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic [DurW-1:0] mark_us;
    logic [DurW-1:0] space_us;
    logic            last_pair;
  } pair_t;

  typedef struct packed {
    status_e    frame_status;
    logic [7:0] address;
    logic [7:0] command;
  } result_t;

  // open window around a target: lo < d < hi
  typedef struct packed {
    logic [DurW-1:0] lo;
    logic [DurW:0]   hi;
  } thr_t;

  // which targets the current pair lies near
  typedef struct packed {
    logic hdr_mark;
    logic hdr_space;
    logic rep_space;
    logic bit_mark;
    logic zero_space;
    logic one_space;
  } match_t;

  localparam logic [DurW-1:0] RST_HDR_MARK   = 15'd9000;
  localparam logic [DurW-1:0] RST_HDR_SPACE  = 15'd4500;
  localparam logic [DurW-1:0] RST_REP_SPACE  = 15'd2250;
  localparam logic [DurW-1:0] RST_BIT_MARK   = 15'd560;
  localparam logic [DurW-1:0] RST_ZERO_SPACE = 15'd560;
  localparam logic [DurW-1:0] RST_ONE_SPACE  = 15'd1690;

  localparam int unsigned DataPairs = 32;
  localparam logic [7:0]  ByteOnes  = 8'hFF;

  // floor(3t/4) and floor(5t/4)
  function automatic thr_t thr_of(logic [DurW-1:0] t);
    logic [DurW+1:0] p3;
    logic [DurW+2:0] p5;
    thr_t            r;
    p3   = {1'b0, t, 1'b0} + {2'b00, t};
    p5   = {1'b0, t, 2'b00} + {3'b000, t};
    r.lo = p3[DurW+1:2];
    r.hi = p5[DurW+2:2];
    return r;
  endfunction

  function automatic logic is_near(logic [DurW-1:0] d, thr_t w);
    return (d > w.lo) && ({1'b0, d} < w.hi);
  endfunction

endpackage

// ----- design/necird_intf.sv -----
// ----------------------------------------------------------------------------
// necird channel interfaces
// valid/ready channels for pulse pairs and decoded results
// ----------------------------------------------------------------------------
interface necird_pair_if;
  logic                valid;
  logic                ready;
  necird_pkg::pair_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface necird_result_if;
  logic                valid;
  logic                ready;
  necird_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/necird_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// necird_cfg_regs
// target registers, kept as precomputed near windows
// ----------------------------------------------------------------------------
module necird_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [necird_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  logic [necird_pkg::DurW-1:0]           cfg_data_i,
  output necird_pkg::thr_t [necird_pkg::NumRegs-1:0] thr_o
);
  import necird_pkg::*;

  thr_t [NumRegs-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[REG_HDR_MARK]   <= thr_of(RST_HDR_MARK);
      thr_q[REG_HDR_SPACE]  <= thr_of(RST_HDR_SPACE);
      thr_q[REG_REP_SPACE]  <= thr_of(RST_REP_SPACE);
      thr_q[REG_BIT_MARK]   <= thr_of(RST_BIT_MARK);
      thr_q[REG_ZERO_SPACE] <= thr_of(RST_ZERO_SPACE);
      thr_q[REG_ONE_SPACE]  <= thr_of(RST_ONE_SPACE);
    end else if (cfg_we_i && (cfg_idx_i <= REG_ONE_SPACE)) begin
      thr_q[cfg_idx_i] <= thr_of(cfg_data_i);
    end
  end

  assign thr_o = thr_q;

endmodule

// ----- design/necird_pair_match.sv -----
// ----------------------------------------------------------------------------
// necird_pair_match
// compares one registered pulse pair against all near windows
// ----------------------------------------------------------------------------
module necird_pair_match (
  input  necird_pkg::pair_t                          pair_i,
  input  necird_pkg::thr_t [necird_pkg::NumRegs-1:0] thr_i,
  output necird_pkg::match_t                         match_o
);
  import necird_pkg::*;

  always_comb begin
    match_o.hdr_mark   = is_near(pair_i.mark_us,  thr_i[REG_HDR_MARK]);
    match_o.hdr_space  = is_near(pair_i.space_us, thr_i[REG_HDR_SPACE]);
    match_o.rep_space  = is_near(pair_i.space_us, thr_i[REG_REP_SPACE]);
    match_o.bit_mark   = is_near(pair_i.mark_us,  thr_i[REG_BIT_MARK]);
    match_o.zero_space = is_near(pair_i.space_us, thr_i[REG_ZERO_SPACE]);
    match_o.one_space  = is_near(pair_i.space_us, thr_i[REG_ONE_SPACE]);
  end

endmodule

// ----- design/necird_frame.sv -----
// ----------------------------------------------------------------------------
// necird_frame
// frame state, bit collection and the result register
// ----------------------------------------------------------------------------
module necird_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pair_valid_i,
  input  necird_pkg::pair_t  pair_i,
  input  necird_pkg::match_t match_i,
  output logic               pair_take_o,
  necird_result_if.source    result_o
);
  import necird_pkg::*;

  logic [5:0]  pair_index_q, pair_index_d;
  logic [31:0] bit_word_q, bit_word_d;
  logic        frame_bad_q, frame_bad_d;
  logic        rep_seen_q, rep_seen_d;
  logic        res_valid_q;
  result_t     res_q, res_d;

  logic        is_hdr, is_data, out_free;
  logic [4:0]  bit_pos;
  logic [7:0]  cmd_byte, cmd_inv_byte;

  assign out_free    = !res_valid_q || result_o.ready;
  // a pair with no result never waits on the output side
  assign pair_take_o = pair_valid_i && (!pair_i.last_pair || out_free);

  assign is_hdr  = (pair_index_q == '0);
  assign is_data = !is_hdr && (pair_index_q <= 6'(DataPairs));
  assign bit_pos = 5'(pair_index_q - 6'd1);

  always_comb begin
    frame_bad_d = frame_bad_q;
    rep_seen_d  = rep_seen_q;
    bit_word_d  = bit_word_q;
    if (is_hdr) begin
      if (!(match_i.hdr_mark && match_i.hdr_space)) frame_bad_d = 1'b1;
      rep_seen_d = match_i.hdr_mark && match_i.rep_space;
    end else if (is_data) begin
      if (!match_i.bit_mark) begin
        frame_bad_d = 1'b1;
      end else if (match_i.one_space) begin
        bit_word_d[bit_pos] = 1'b1;
      end else if (!match_i.zero_space) begin
        frame_bad_d = 1'b1;
      end
    end
    pair_index_d = (pair_index_q == 6'h3F) ? pair_index_q : pair_index_q + 6'd1;

    cmd_byte     = bit_word_d[23:16];
    cmd_inv_byte = bit_word_d[31:24];
    res_d.frame_status = ST_INVALID;
    res_d.address      = '0;
    res_d.command      = '0;
    // at least 33 pairs means the current index is 32 or more
    if ((pair_index_q >= 6'(DataPairs)) && !frame_bad_d &&
        ((cmd_byte ^ cmd_inv_byte) == ByteOnes)) begin
      res_d.frame_status = ST_VALID;
      res_d.address      = bit_word_d[7:0];
      res_d.command      = cmd_byte;
    end else if (!is_hdr && rep_seen_d) begin
      res_d.frame_status = ST_REPEAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_index_q <= '0;
      bit_word_q   <= '0;
      frame_bad_q  <= 1'b0;
      rep_seen_q   <= 1'b0;
    end else if (pair_take_o) begin
      if (pair_i.last_pair) begin
        pair_index_q <= '0;
        bit_word_q   <= '0;
        frame_bad_q  <= 1'b0;
        rep_seen_q   <= 1'b0;
      end else begin
        pair_index_q <= pair_index_d;
        bit_word_q   <= bit_word_d;
        frame_bad_q  <= frame_bad_d;
        rep_seen_q   <= rep_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= pair_take_o && pair_i.last_pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pair_take_o && pair_i.last_pair) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

endmodule

// ----- design/nec_ir_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_unit
// decodes nec infrared frames from measured mark/space pulse pairs
// ----------------------------------------------------------------------------
// One pulse pair per clock: a pair is caught in the input register, checked
// against the six near windows and folded into the frame state, and the pair
// that ends a frame loads the result register. The windows are worked out
// when a target register is written, which leaves two compares per target
// in the pair path. A stalled result holds back only last pairs; other pairs
// keep flowing in underneath it.
module nec_ir_frame_decoder_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [necird_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [necird_pkg::DurW-1:0]    cfg_data_i,
  necird_pair_if.sink                    pair_i,
  necird_result_if.source                result_o
);
  import necird_pkg::*;

  thr_t [NumRegs-1:0] thr;
  match_t             match;
  pair_t              pair_q;
  logic               pair_valid_q;
  logic               pair_take;

  assign pair_i.ready = !pair_valid_q || pair_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
    end else if (pair_i.ready) begin
      pair_valid_q <= pair_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.ready && pair_i.valid) begin
      pair_q <= pair_i.payload;
    end
  end

  necird_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .thr_o      (thr)
  );

  necird_pair_match u_match (
    .pair_i  (pair_q),
    .thr_i   (thr),
    .match_o (match)
  );

  necird_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid_q),
    .pair_i       (pair_q),
    .match_i      (match),
    .pair_take_o  (pair_take),
    .result_o     (result_o)
  );

endmodule

// ----- design/necird_checker.sv -----
// ----------------------------------------------------------------------------
// necird_checker
// port level checks of the nec ir frame decoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module necird_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] frame_status_i,
  input logic [7:0] address_i,
  input logic [7:0] command_i
);
  import necird_pkg::*;

  // a stalled result keeps its valid and its payload
  `NECIRD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `NECIRD_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable({frame_status_i, address_i, command_i}), "result changed under stall")
  // with no pending result the block always takes a request
  `NECIRD_ASSERT(a_in_ready, !out_valid_i |-> in_ready_i, "request refused with empty output")
  // only a valid frame carries address and command
  `NECIRD_NEVER(a_zero_fields, out_valid_i && (frame_status_i != ST_VALID) && ((address_i != '0) || (command_i != '0)), "fields set on non-valid status")

endmodule

bind nec_ir_frame_decoder_unit necird_checker u_necird_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (pair_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .frame_status_i (result_o.payload.frame_status),
  .address_i      (result_o.payload.address),
  .command_i      (result_o.payload.command)
);

// ----- tb/sv/nec_ir_frame_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_unit_tb
// drives pulse pairs into the nec ir decoder under several target settings
// and idle patterns, predicts every frame status and checks it in order
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_unit_tb;
  import necird_pkg::*;

  localparam int unsigned CycleLimit  = 150000;
  localparam int unsigned DrainCycles = 8;

  typedef enum int {
    FR_VALID,
    FR_CORRUPT,
    FR_REPEAT,
    FR_NOISE,
    FR_LONG,
    FR_SINGLE,
    FR_BAD_REPEAT
  } frame_kind_e;

  // frame status predictor and store of expected statuses
  class nec_frame_scoreboard;
    bit [DurW-1:0] targets[NumRegs];
    bit [5:0]      pair_idx;
    bit [31:0]     data_bits;
    bit            frame_bad;
    bit            rep_seen;
    result_t       expected_results[$];
    int unsigned   fail_count;

    function new();
      targets[REG_HDR_MARK]   = RST_HDR_MARK;
      targets[REG_HDR_SPACE]  = RST_HDR_SPACE;
      targets[REG_REP_SPACE]  = RST_REP_SPACE;
      targets[REG_BIT_MARK]   = RST_BIT_MARK;
      targets[REG_ZERO_SPACE] = RST_ZERO_SPACE;
      targets[REG_ONE_SPACE]  = RST_ONE_SPACE;
      fail_count = 0;
      clear_frame();
    endfunction

    static function bit near_target(bit [DurW-1:0] d, bit [DurW-1:0] t);
      int unsigned lo, hi;
      lo = (32'(t) * 3) / 4;
      hi = (32'(t) * 5) / 4;
      return (d > lo) && (d < hi);
    endfunction

    function void clear_frame();
      pair_idx  = '0;
      data_bits = '0;
      frame_bad = 1'b0;
      rep_seen  = 1'b0;
    endfunction

    function void set_target(reg_idx_e idx, bit [DurW-1:0] v);
      targets[idx] = v;
    endfunction

    function void note_pair(pair_t p);
      int unsigned count;
      bit          mark_ok;
      bit [7:0]    cmd, cmd_inv;
      result_t     r;
      if (pair_idx == 0) begin
        mark_ok = near_target(p.mark_us, targets[REG_HDR_MARK]);
        if (!mark_ok || !near_target(p.space_us, targets[REG_HDR_SPACE]))
          frame_bad = 1'b1;
        rep_seen = mark_ok && near_target(p.space_us, targets[REG_REP_SPACE]);
      end else if (pair_idx <= DataPairs) begin
        if (!near_target(p.mark_us, targets[REG_BIT_MARK]))
          frame_bad = 1'b1;
        else if (near_target(p.space_us, targets[REG_ONE_SPACE]))
          data_bits[pair_idx - 1] = 1'b1;
        else if (!near_target(p.space_us, targets[REG_ZERO_SPACE]))
          frame_bad = 1'b1;
      end
      count = pair_idx + 1;
      if (pair_idx < 63)
        pair_idx++;
      if (!p.last_pair)
        return;
      cmd     = data_bits[23:16];
      cmd_inv = data_bits[31:24];
      r.frame_status = ST_INVALID;
      r.address      = '0;
      r.command      = '0;
      if (count >= DataPairs + 1 && !frame_bad && (cmd ^ cmd_inv) == ByteOnes) begin
        r.frame_status = ST_VALID;
        r.address      = data_bits[7:0];
        r.command      = cmd;
      end else if (count >= 2 && rep_seen) begin
        r.frame_status = ST_REPEAT;
      end
      expected_results.push_back(r);
      clear_frame();
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d addr %02h cmd %02h",
                   got.frame_status, got.address, got.command);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.frame_status !== exp_r.frame_status || got.address !== exp_r.address ||
          got.command !== exp_r.command) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result mismatch: expected status %0d addr %02h cmd %02h, %s %0d %s %02h %s %02h",
                   exp_r.frame_status, exp_r.address, exp_r.command,
                   "got status", got.frame_status, "addr", got.address,
                   "cmd", got.command);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RegIdxW-1:0]  cfg_idx_i;
  logic [DurW-1:0]     cfg_data_i;

  necird_pair_if   pair_if ();
  necird_result_if res_if ();

  nec_ir_frame_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pair_i     (pair_if),
    .result_o   (res_if)
  );

  nec_frame_scoreboard sb;
  int unsigned items_sent;
  int unsigned cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          stall_left;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check accepted results, then decide ready for the next cycle
  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result(res_if.payload);
    if (rst_ni !== 1'b1) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic pair_t make_pair(bit [DurW-1:0] m, bit [DurW-1:0] s, bit l);
    pair_t p;
    p.mark_us   = m;
    p.space_us  = s;
    p.last_pair = l;
    return p;
  endfunction

  function automatic bit [DurW-1:0] near_val(bit [DurW-1:0] t);
    int unsigned lo, hi;
    lo = (32'(t) * 3) / 4;
    hi = (32'(t) * 5) / 4;
    if (hi > 32768)
      hi = 32768;
    if (hi > lo + 1)
      return DurW'($urandom_range(hi - 1, lo + 1));
    return DurW'($urandom_range(32767));
  endfunction

  function automatic bit [DurW-1:0] far_val(bit [DurW-1:0] t);
    int unsigned lo, hi;
    bit [DurW-1:0] v;
    lo = (32'(t) * 3) / 4;
    hi = (32'(t) * 5) / 4;
    case ($urandom_range(2))
      0:       v = DurW'(lo);
      1:       v = (hi > 32767) ? '0 : DurW'(hi);
      default: v = DurW'($urandom_range(32767));
    endcase
    if (nec_frame_scoreboard::near_target(v, t))
      v = DurW'(lo);
    return v;
  endfunction

  function automatic pair_t data_pair(bit b);
    return make_pair(near_val(sb.targets[REG_BIT_MARK]),
                     b ? near_val(sb.targets[REG_ONE_SPACE])
                       : near_val(sb.targets[REG_ZERO_SPACE]), 1'b0);
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 45) return FR_VALID;
    if (r < 60) return FR_CORRUPT;
    if (r < 75) return FR_REPEAT;
    if (r < 85) return FR_NOISE;
    if (r < 90) return FR_LONG;
    if (r < 95) return FR_SINGLE;
    return FR_BAD_REPEAT;
  endfunction

  task automatic send_pair(pair_t p);
    if (items_sent < 520) begin
      tx_idle_pct = 21;
      rx_idle_pct = 49;
    end else if (items_sent < 1040) begin
      tx_idle_pct = 49;
      rx_idle_pct = 21;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_if.valid   <= 1'b1;
    pair_if.payload <= p;
    do
      @(posedge clk_i);
    while (pair_if.ready !== 1'b1);
    sb.note_pair(p);
    items_sent++;
  endtask

  task automatic send_frame(frame_kind_e kind);
    pair_t         fq[$];
    pair_t         p;
    bit [31:0]     word;
    bit [DurW-1:0] v;
    int            n, pos, sub;
    word = $urandom;
    word[31:24] = ~word[23:16];
    sub = $urandom_range(4);
    pos = $urandom_range(1, 32);
    if (kind == FR_CORRUPT && sub == 3)
      word[24 + $urandom_range(7)] = ~word[24 + $urandom_range(7)];
    case (kind)
      FR_VALID, FR_CORRUPT, FR_LONG: begin
        fq.push_back(make_pair(near_val(sb.targets[REG_HDR_MARK]),
                               near_val(sb.targets[REG_HDR_SPACE]), 1'b0));
        for (int i = 0; i < 32; i++)
          fq.push_back(data_pair(word[i]));
        if (kind == FR_LONG)
          n = $urandom_range(10, 37);
        else
          n = ($urandom_range(4) == 0) ? $urandom_range(1, 5) : 0;
        repeat (n) fq.push_back(data_pair(1'($urandom_range(1))));
        if (kind == FR_CORRUPT) begin
          case (sub)
            0: begin
              p = fq[0];
              p.space_us = far_val(sb.targets[REG_HDR_SPACE]);
              fq[0] = p;
            end
            1: begin
              p = fq[pos];
              p.mark_us = far_val(sb.targets[REG_BIT_MARK]);
              fq[pos] = p;
            end
            2: begin
              // space off the one window, moved off the zero window if it falls in it
              v = far_val(sb.targets[REG_ONE_SPACE]);
              if (nec_frame_scoreboard::near_target(v, sb.targets[REG_ZERO_SPACE]))
                v = far_val(sb.targets[REG_ZERO_SPACE]);
              p = fq[pos];
              p.space_us = v;
              fq[pos] = p;
            end
            4: fq = fq[0:pos];
            default: ;
          endcase
        end
      end
      FR_REPEAT: begin
        fq.push_back(make_pair(near_val(sb.targets[REG_HDR_MARK]),
                               near_val(sb.targets[REG_REP_SPACE]), 1'b0));
        n = $urandom_range(1, 3);
        repeat (n) fq.push_back(data_pair(1'($urandom_range(1))));
      end
      FR_BAD_REPEAT: begin
        fq.push_back(make_pair(far_val(sb.targets[REG_HDR_MARK]),
                               near_val(sb.targets[REG_REP_SPACE]), 1'b0));
        fq.push_back(data_pair(1'($urandom_range(1))));
      end
      FR_SINGLE: begin
        fq.push_back(make_pair(near_val(sb.targets[REG_HDR_MARK]),
                               near_val(sb.targets[REG_HDR_SPACE]), 1'b0));
      end
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) fq.push_back(make_pair(DurW'($urandom_range(32767)),
                                          DurW'($urandom_range(32767)), 1'b0));
      end
    endcase
    p = fq[fq.size() - 1];
    p.last_pair = 1'b1;
    fq[fq.size() - 1] = p;
    foreach (fq[i])
      send_pair(fq[i]);
  endtask

  // let every expected status arrive, then give the pipe time to empty
  task automatic wait_idle();
    pair_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic put_target(reg_idx_e idx, bit [DurW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_target(idx, v);
  endtask

  task automatic load_targets(bit [DurW-1:0] hm, bit [DurW-1:0] hs, bit [DurW-1:0] rs,
                              bit [DurW-1:0] bm, bit [DurW-1:0] zs, bit [DurW-1:0] os);
    wait_idle();
    put_target(REG_HDR_MARK, hm);
    put_target(REG_HDR_SPACE, hs);
    put_target(REG_REP_SPACE, rs);
    put_target(REG_BIT_MARK, bm);
    put_target(REG_ZERO_SPACE, zs);
    put_target(REG_ONE_SPACE, os);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned until_items);
    while (items_sent < until_items)
      send_frame(pick_kind());
  endtask

  initial begin
    sb = new();
    items_sent    = 0;
    cycle_count   = 0;
    tx_idle_pct   = 21;
    rx_idle_pct   = 49;
    stall_left    = 0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_HDR_MARK;
    cfg_data_i      <= '0;
    pair_if.valid   <= 1'b0;
    pair_if.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs at the reset targets
    send_pair(make_pair(15'd9000, 15'd4500, 1'b1));   // lone header
    send_pair(make_pair(15'd9000, 15'd2250, 1'b0));   // repeat code
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd0, 15'd0, 1'b1));
    send_pair(make_pair(15'd32767, 15'd32767, 1'b1));
    send_pair(make_pair(15'd32767, 15'd32767, 1'b0));
    send_pair(make_pair(15'd0, 15'd0, 1'b1));
    // header mark on and just inside the window edges
    send_pair(make_pair(15'd6750, 15'd2250, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd6751, 15'd2250, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd11250, 15'd2250, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd11249, 15'd2250, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd9000, 15'd2250, 1'b1));   // repeat header alone
    send_pair(make_pair(15'd9000, 15'd4500, 1'b0));
    send_pair(make_pair(15'd560, 15'd1690, 1'b1));
    send_pair(make_pair(15'd9000, 15'd1687, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));
    send_pair(make_pair(15'd9000, 15'd2812, 1'b0));
    send_pair(make_pair(15'd560, 15'd560, 1'b1));

    run_random(350);
    load_targets(15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767);
    run_random(470);
    load_targets(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
    run_random(530);
    // zero and one windows overlap: a space near both reads as one
    load_targets(15'd9000, 15'd4500, 15'd2250, 15'd560, 15'd560, 15'd600);
    run_random(790);
    load_targets(DurW'($urandom_range(100, 20000)), DurW'($urandom_range(100, 20000)),
                 DurW'($urandom_range(100, 20000)), DurW'($urandom_range(1, 20000)),
                 DurW'($urandom_range(1, 20000)), DurW'($urandom_range(1, 20000)));
    run_random(950);
    load_targets(DurW'($urandom_range(32767)), DurW'($urandom_range(32767)),
                 DurW'($urandom_range(32767)), DurW'($urandom_range(32767)),
                 DurW'($urandom_range(32767)), DurW'($urandom_range(32767)));
    run_random(1110);
    load_targets(RST_HDR_MARK, RST_HDR_SPACE, RST_REP_SPACE,
                 RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE);
    // long result stall while repeat codes keep coming
    stall_left = 400;
    repeat (14) send_frame(FR_REPEAT);
    run_random(1550);

    wait_idle();
    if (sb.fail_count == 0 && sb.expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/necird_pkg.sv
design/necird_intf.sv
design/necird_cfg_regs.sv
design/necird_pair_match.sv
design/necird_frame.sv
design/nec_ir_frame_decoder_unit.sv
design/necird_checker.sv
tb/sv/nec_ir_frame_decoder_unit_tb.sv
